[rtl/nss_pkg.sv]
// shared types, codes and sizes for the nearest shapes top-k selector
package nss_pkg;

  // list geometry
  localparam int unsigned MAX_LIST = 32;
  localparam int unsigned IDX_W    = $clog2(MAX_LIST);
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned RANK_W   = 6;

  // field widths
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned HALF_W   = 13;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned DIST_W   = 27;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_IDX_W = 2;

  // constants of the selection rule
  localparam logic [RANK_W-1:0]  NOT_KEPT    = RANK_W'(32);
  localparam logic [DIST_W-1:0]  MIN_DIST_SQ = DIST_W'(36);
  localparam logic [DIST_W-1:0]  DIST_ONES   = {DIST_W{1'b1}};
  localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(20);
  localparam logic [COORD_W-1:0] COORD_MAX   = {COORD_W{1'b1}};

  // request codes on the input channel
  localparam logic [1:0] REQ_POINT = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIST_LEN = 2'd2;

  // result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  // command queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    CMD_SHAPE,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ID_W-1:0]    id;
    logic [HALF_W-1:0]  cx;
    logic [HALF_W-1:0]  cy;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [HALF_W-1:0] center_x;
    logic [HALF_W-1:0] center_y;
    logic [LEN_W-1:0]  list_len;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_SUM,
    S_CMP,
    S_INS,
    S_RD
  } back_state_t;

endpackage

[rtl/nss_front.sv]
// front end: takes words, tracks the contour bounding box, issues commands
module nss_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [nss_pkg::COORD_W-1:0]   in_point_x,
  input  logic [nss_pkg::COORD_W-1:0]   in_point_y,
  input  logic                          in_last_point,
  input  nss_pkg::q_stat_t              q_stat,
  output logic                          push,
  output nss_pkg::cmd_t                 push_cmd
);

  logic [nss_pkg::COORD_W-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [nss_pkg::COORD_W-1:0] min_x_nxt, max_x_nxt, min_y_nxt, max_y_nxt;
  logic [nss_pkg::ID_W-1:0]    count_r, count_nxt;
  logic [nss_pkg::COORD_W-1:0] min_x_upd, max_x_upd, min_y_upd, max_y_upd;
  logic                        accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // box including the current point
  always_comb begin
    min_x_upd = (in_point_x < min_x_r) ? in_point_x : min_x_r;
    max_x_upd = (in_point_x > max_x_r) ? in_point_x : max_x_r;
    min_y_upd = (in_point_y < min_y_r) ? in_point_y : min_y_r;
    max_y_upd = (in_point_y > max_y_r) ? in_point_y : max_y_r;
  end

  // request decode
  always_comb begin
    min_x_nxt     = min_x_r;
    max_x_nxt     = max_x_r;
    min_y_nxt     = min_y_r;
    max_y_nxt     = max_y_r;
    count_nxt     = count_r;
    push          = 1'b0;
    push_cmd.kind = nss_pkg::CMD_SHAPE;
    push_cmd.id   = count_r;
    // box centre in half-pixel units
    push_cmd.cx   = {1'b0, min_x_upd} + {1'b0, max_x_upd} + nss_pkg::HALF_W'(1);
    push_cmd.cy   = {1'b0, min_y_upd} + {1'b0, max_y_upd} + nss_pkg::HALF_W'(1);
    if (accept) begin
      case (in_req_type)
        nss_pkg::REQ_POINT: begin
          if (in_last_point) begin
            push      = 1'b1;
            count_nxt = count_r + nss_pkg::ID_W'(1);
            min_x_nxt = nss_pkg::COORD_MAX;
            max_x_nxt = '0;
            min_y_nxt = nss_pkg::COORD_MAX;
            max_y_nxt = '0;
          end else begin
            min_x_nxt = min_x_upd;
            max_x_nxt = max_x_upd;
            min_y_nxt = min_y_upd;
            max_y_nxt = max_y_upd;
          end
        end
        nss_pkg::REQ_CLEAR: begin
          push          = 1'b1;
          push_cmd.kind = nss_pkg::CMD_CLEAR;
          count_nxt     = '0;
          min_x_nxt     = nss_pkg::COORD_MAX;
          max_x_nxt     = '0;
          min_y_nxt     = nss_pkg::COORD_MAX;
          max_y_nxt     = '0;
        end
        nss_pkg::REQ_READ: begin
          push          = 1'b1;
          push_cmd.kind = nss_pkg::CMD_READ;
        end
        default: begin
        end
      endcase
    end
  end

  // box and contour counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= nss_pkg::COORD_MAX;
      max_x_r <= '0;
      min_y_r <= nss_pkg::COORD_MAX;
      max_y_r <= '0;
      count_r <= '0;
    end else begin
      min_x_r <= min_x_nxt;
      max_x_r <= max_x_nxt;
      min_y_r <= min_y_nxt;
      max_y_r <= max_y_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[rtl/nss_cmd_fifo.sv]
// short command queue between front end and list engine
module nss_cmd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  nss_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output nss_pkg::cmd_t    head_cmd,
  output nss_pkg::q_stat_t q_stat
);

  nss_pkg::cmd_t                 ent_r [nss_pkg::QDEPTH];
  logic [nss_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [nss_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [nss_pkg::QPTR_W:0]      cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign q_stat.full  = (cnt_r == (nss_pkg::QPTR_W+1)'(nss_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head_cmd     = ent_r[rd_ptr_r];

  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + nss_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + nss_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (nss_pkg::QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (nss_pkg::QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/nss_back.sv]
// list engine: distance, sorted insert, list readout and result register
module nss_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nss_pkg::cfg_t                cfg,
  input  nss_pkg::q_stat_t             q_stat,
  input  nss_pkg::cmd_t                head_cmd,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_result_kind,
  output logic [nss_pkg::RANK_W-1:0]   out_rank,
  output logic [nss_pkg::ID_W-1:0]     out_shape_id,
  output logic [nss_pkg::DIST_W-1:0]   out_dist_sq,
  output logic                         out_entry_valid,
  output logic                         out_last_result
);

  localparam int unsigned N = nss_pkg::MAX_LIST;

  nss_pkg::back_state_t           state_r, state_nxt;
  nss_pkg::cmd_t                  cmd_r, cmd_nxt;
  logic [nss_pkg::DIST_W-1:0]     sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [nss_pkg::DIST_W-1:0]     d_r, d_nxt;
  logic [N-1:0]                   hit_r, hit_nxt;
  logic [nss_pkg::IDX_W-1:0]      idx_r, idx_nxt;

  logic [nss_pkg::DIST_W-1:0]     slot_dist_r [N];
  logic [nss_pkg::DIST_W-1:0]     slot_dist_nxt [N];
  logic [nss_pkg::ID_W-1:0]       slot_id_r [N];
  logic [nss_pkg::ID_W-1:0]       slot_id_nxt [N];
  logic [N-1:0]                   slot_full_r, slot_full_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic                           out_kind_r, out_kind_nxt;
  logic [nss_pkg::RANK_W-1:0]     out_rank_r, out_rank_nxt;
  logic [nss_pkg::ID_W-1:0]       out_id_r, out_id_nxt;
  logic [nss_pkg::DIST_W-1:0]     out_dist_r, out_dist_nxt;
  logic                           out_ev_r, out_ev_nxt;
  logic                           out_last_r, out_last_nxt;

  logic [nss_pkg::LEN_W-1:0]      n_used;
  logic                           out_free;
  logic signed [nss_pkg::HALF_W:0] dx, dy;
  logic signed [2*nss_pkg::HALF_W+1:0] px, py;
  logic [nss_pkg::DIST_W:0]       dsum;
  logic [nss_pkg::IDX_W-1:0]      rank_sel;
  logic                           kept;

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_rank        = out_rank_r;
  assign out_shape_id    = out_id_r;
  assign out_dist_sq     = out_dist_r;
  assign out_entry_valid = out_ev_r;
  assign out_last_result = out_last_r;

  // slots in use: zero counts as one, capped at the list size
  always_comb begin
    if (cfg.list_len == '0) begin
      n_used = nss_pkg::LEN_W'(1);
    end else if (cfg.list_len > nss_pkg::LEN_W'(N)) begin
      n_used = nss_pkg::LEN_W'(N);
    end else begin
      n_used = cfg.list_len;
    end
  end

  // centre offsets and their squares
  always_comb begin
    dx = $signed({1'b0, cmd_r.cx}) - $signed({1'b0, cfg.center_x});
    dy = $signed({1'b0, cmd_r.cy}) - $signed({1'b0, cfg.center_y});
    px = dx * dx;
    py = dy * dy;
    dsum = {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  // first slot that takes the new contour
  always_comb begin
    rank_sel = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (hit_r[k]) begin
        rank_sel = nss_pkg::IDX_W'(k);
      end
    end
    kept = |hit_r;
  end

  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    sqx_nxt       = sqx_r;
    sqy_nxt       = sqy_r;
    d_nxt         = d_r;
    hit_nxt       = hit_r;
    idx_nxt       = idx_r;
    slot_dist_nxt = slot_dist_r;
    slot_id_nxt   = slot_id_r;
    slot_full_nxt = slot_full_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_rank_nxt  = out_rank_r;
    out_id_nxt    = out_id_r;
    out_dist_nxt  = out_dist_r;
    out_ev_nxt    = out_ev_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;

    case (state_r)
      nss_pkg::S_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          cmd_nxt = head_cmd;
          case (head_cmd.kind)
            nss_pkg::CMD_SHAPE: begin
              state_nxt = nss_pkg::S_SQ;
            end
            nss_pkg::CMD_READ: begin
              idx_nxt   = '0;
              state_nxt = nss_pkg::S_RD;
            end
            nss_pkg::CMD_CLEAR: begin
              for (int k = 0; k < N; k++) begin
                slot_dist_nxt[k] = nss_pkg::DIST_ONES;
                slot_id_nxt[k]   = '0;
              end
              slot_full_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      nss_pkg::S_SQ: begin
        sqx_nxt   = px[nss_pkg::DIST_W-1:0];
        sqy_nxt   = py[nss_pkg::DIST_W-1:0];
        state_nxt = nss_pkg::S_SUM;
      end
      nss_pkg::S_SUM: begin
        d_nxt     = dsum[nss_pkg::DIST_W-1:0];
        state_nxt = nss_pkg::S_CMP;
      end
      nss_pkg::S_CMP: begin
        // per-slot compare, ties do not displace
        for (int k = 0; k < N; k++) begin
          hit_nxt[k] = (nss_pkg::LEN_W'(k) < n_used)
                       && (!slot_full_r[k] || (d_r < slot_dist_r[k]))
                       && (d_r > nss_pkg::MIN_DIST_SQ);
        end
        state_nxt = nss_pkg::S_INS;
      end
      nss_pkg::S_INS: begin
        if (out_free) begin
          // shift later entries down and drop in the new one
          if (kept) begin
            for (int m = 0; m < N; m++) begin
              if (nss_pkg::IDX_W'(m) == rank_sel) begin
                slot_dist_nxt[m] = d_r;
                slot_id_nxt[m]   = cmd_r.id;
                slot_full_nxt[m] = 1'b1;
              end else if ((nss_pkg::IDX_W'(m) > rank_sel)
                           && (nss_pkg::LEN_W'(m) < n_used)) begin
                slot_dist_nxt[m] = slot_dist_r[(m == 0) ? 0 : m - 1];
                slot_id_nxt[m]   = slot_id_r[(m == 0) ? 0 : m - 1];
                slot_full_nxt[m] = slot_full_r[(m == 0) ? 0 : m - 1];
              end
            end
          end
          out_valid_nxt = 1'b1;
          out_kind_nxt  = nss_pkg::KIND_REPORT;
          out_rank_nxt  = kept ? {1'b0, rank_sel} : nss_pkg::NOT_KEPT;
          out_id_nxt    = cmd_r.id;
          out_dist_nxt  = d_r;
          out_ev_nxt    = kept;
          out_last_nxt  = 1'b1;
          state_nxt     = nss_pkg::S_IDLE;
        end
      end
      nss_pkg::S_RD: begin
        // one list entry per word
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = nss_pkg::KIND_ENTRY;
          out_rank_nxt  = {1'b0, idx_r};
          out_id_nxt    = slot_id_r[idx_r];
          out_dist_nxt  = slot_dist_r[idx_r];
          out_ev_nxt    = slot_full_r[idx_r];
          out_last_nxt  = ({1'b0, idx_r} == n_used - nss_pkg::LEN_W'(1));
          if ({1'b0, idx_r} == n_used - nss_pkg::LEN_W'(1)) begin
            state_nxt = nss_pkg::S_IDLE;
          end else begin
            idx_nxt = idx_r + nss_pkg::IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = nss_pkg::S_IDLE;
      end
    endcase
  end

  // control state and list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nss_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      slot_full_r <= '0;
      for (int k = 0; k < N; k++) begin
        slot_dist_r[k] <= nss_pkg::DIST_ONES;
        slot_id_r[k]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      slot_full_r <= slot_full_nxt;
      slot_dist_r <= slot_dist_nxt;
      slot_id_r   <= slot_id_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    sqx_r      <= sqx_nxt;
    sqy_r      <= sqy_nxt;
    d_r        <= d_nxt;
    hit_r      <= hit_nxt;
    idx_r      <= idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_rank_r <= out_rank_nxt;
    out_id_r   <= out_id_nxt;
    out_dist_r <= out_dist_nxt;
    out_ev_r   <= out_ev_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

[rtl/nearest_shapes_topk_selector_core.sv]
// Nearest shapes top-k selector: contour points go in one word per cycle
// while the command queue is not full; a point that does not end a contour
// only widens the bounding box. A contour's last point, a clear and a read
// each go through a four-entry command queue to the list engine, so the
// front keeps taking points while the engine works. The engine handles a
// finished contour in steps (dequeue, centre offset squares, sum, per-slot
// compare, then the shifting insert and its report word), clears the list
// as it dequeues a clear, and on a readout dequeues and then gives one word
// per slot in use. The insert and each readout word wait while the output
// register is stalled. The input stalls only while the queue is full.
// A result word is held in an output register until taken.
module nearest_shapes_topk_selector_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [nss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nss_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_req_type,
  input  logic [nss_pkg::COORD_W-1:0]        in_point_x,
  input  logic [nss_pkg::COORD_W-1:0]        in_point_y,
  input  logic                               in_last_point,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_result_kind,
  output logic [nss_pkg::RANK_W-1:0]         out_rank,
  output logic [nss_pkg::ID_W-1:0]           out_shape_id,
  output logic [nss_pkg::DIST_W-1:0]         out_dist_sq,
  output logic                               out_entry_valid,
  output logic                               out_last_result
);

  nss_pkg::cfg_t    cfg_r, cfg_nxt;
  nss_pkg::q_stat_t q_stat;
  nss_pkg::cmd_t    push_cmd, head_cmd;
  logic             push, pop;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        nss_pkg::REG_CENTER_X: cfg_nxt.center_x = cfg_data;
        nss_pkg::REG_CENTER_Y: cfg_nxt.center_y = cfg_data;
        nss_pkg::REG_LIST_LEN: cfg_nxt.list_len = cfg_data[nss_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x <= '0;
      cfg_r.center_y <= '0;
      cfg_r.list_len <= nss_pkg::LEN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  nss_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_last_point (in_last_point),
    .q_stat        (q_stat),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  nss_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  nss_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_stat          (q_stat),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_rank        (out_rank),
    .out_shape_id    (out_shape_id),
    .out_dist_sq     (out_dist_sq),
    .out_entry_valid (out_entry_valid),
    .out_last_result (out_last_result)
  );

endmodule

[rtl/nss_checker.sv]
// port-level checks for the selector, bound to the top level
module nss_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_result_kind,
  input logic [nss_pkg::RANK_W-1:0]        out_rank,
  input logic [nss_pkg::ID_W-1:0]          out_shape_id,
  input logic [nss_pkg::DIST_W-1:0]        out_dist_sq,
  input logic                              out_entry_valid,
  input logic                              out_last_result
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rank)
      && $stable(out_shape_id) && $stable(out_dist_sq))
    else $error("result word changed while stalled");

  // an insertion report is a single word
  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == nss_pkg::KIND_REPORT) |-> out_last_result)
    else $error("insertion report not marked last");

  // kept flag matches the rank
  a_report_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == nss_pkg::KIND_REPORT)
      |-> (out_entry_valid == (out_rank != nss_pkg::NOT_KEPT)))
    else $error("report rank and kept flag disagree");

  // a kept contour is farther than the minimum distance
  a_report_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == nss_pkg::KIND_REPORT) && out_entry_valid
      |-> (out_dist_sq > nss_pkg::MIN_DIST_SQ))
    else $error("kept contour too close to the centre");

  // empty slots read as cleared
  a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == nss_pkg::KIND_ENTRY) && !out_entry_valid
      |-> (out_dist_sq == nss_pkg::DIST_ONES) && (out_shape_id == '0))
    else $error("empty slot does not read as cleared");

endmodule

bind nearest_shapes_topk_selector_core nss_checker u_nss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_kind (out_result_kind),
  .out_rank        (out_rank),
  .out_shape_id    (out_shape_id),
  .out_dist_sq     (out_dist_sq),
  .out_entry_valid (out_entry_valid),
  .out_last_result (out_last_result)
);
